FILE: rtl/core/snm_pkg.sv
// Shared types, constants and helpers for the Sobel normal-map generator.
`timescale 1ns / 1ps

package snm_pkg;

	// Field widths
	localparam int PIX_W      = 8;
	localparam int DIM_W      = 11;
	localparam int GAIN_W     = 12;
	localparam int CFG_DATA_W = 12;
	localparam int LUMA_W     = 16;
	localparam int PROD_W     = LUMA_W + GAIN_W;
	localparam int GRAD_W     = 12;

	// Luma weights over 256
	localparam logic [LUMA_W-1:0] LUMA_WR = 16'd77;
	localparam logic [LUMA_W-1:0] LUMA_WG = 16'd151;
	localparam logic [LUMA_W-1:0] LUMA_WB = 16'd28;

	// Register defaults
	localparam logic [DIM_W-1:0]  FRAME_WIDTH_RST  = 11'd1024;
	localparam logic [DIM_W-1:0]  FRAME_HEIGHT_RST = 11'd1024;
	localparam logic [GAIN_W-1:0] HEIGHT_GAIN_RST  = 12'd256;
	localparam logic [PIX_W-1:0]  FLAT_BLUE_RST    = 8'd255;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1,
		REG_HEIGHT_GAIN  = 2'd2,
		REG_FLAT_BLUE    = 2'd3
	} reg_idx_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_WR,
		ST_RD_L,
		ST_RD_C,
		ST_RD_R,
		ST_RD_W,
		ST_EMIT
	} ctrl_state_t;

	// Which window column is being fetched
	typedef enum logic [1:0] {
		COL_LEFT,
		COL_CENTRE,
		COL_RIGHT
	} col_sel_t;

	// Controller to datapath
	typedef struct packed {
		logic     pixel;
		logic     mul;
		logic     write;
		logic     rd_en;
		col_sel_t rd_col;
		logic     shift;
		logic     emit;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic done;
		logic produce;
		logic out_free;
	} dp_stat_t;

	// Row slot arithmetic modulo three
	function automatic logic [1:0] row3_inc(input logic [1:0] r);
		return (r == 2'd2) ? 2'd0 : r + 2'd1;
	endfunction

	function automatic logic [1:0] row3_dec(input logic [1:0] r);
		return (r == 2'd0) ? 2'd2 : r - 2'd1;
	endfunction

	// floor((g + 255) / 2) clamped to 0..255
	function automatic logic [PIX_W-1:0] encode_grad(input logic signed [GRAD_W-1:0] g);
		logic signed [GRAD_W-1:0] s;
		logic signed [GRAD_W-1:0] h;
		s = g + GRAD_W'(255);
		h = s >>> 1;
		if (s < 0)
			return '0;
		else if (h > GRAD_W'(255))
			return '1;
		else
			return h[PIX_W-1:0];
	endfunction

endpackage

FILE: rtl/core/snm_if.sv
// Stream interfaces: source pixel channel and normal pixel channel.
`timescale 1ns / 1ps

interface snm_pix_if;
	import snm_pkg::*;
	logic             valid;
	logic             ready;
	logic             func;
	logic [PIX_W-1:0] pix_red;
	logic [PIX_W-1:0] pix_green;
	logic [PIX_W-1:0] pix_blue;

	modport source (output valid, func, pix_red, pix_green, pix_blue, input ready);
	modport sink   (input valid, func, pix_red, pix_green, pix_blue, output ready);
endinterface

interface snm_nrm_if;
	import snm_pkg::*;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] normal_red;
	logic [PIX_W-1:0] normal_green;
	logic [PIX_W-1:0] normal_blue;
	logic             end_of_frame;

	modport source (output valid, normal_red, normal_green, normal_blue, end_of_frame,
		input ready);
	modport sink   (input valid, normal_red, normal_green, normal_blue, end_of_frame,
		output ready);
endinterface

FILE: rtl/core/snm_ctrl.sv
// Controller state machine: sequences height, store write, window fetch and emit.
`timescale 1ns / 1ps

module snm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_func,
	output logic              in_ready,
	input  snm_pkg::dp_stat_t stat,
	output snm_pkg::dp_cmd_t  cmd
);
	import snm_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_nxt;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_nxt;
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					// once the frame is in, every beat flushes one result
					if (stat.done)
						state_nxt = ST_RD_L;
					else if (!in_func)
						state_nxt = ST_MUL;
				end
			end
			ST_MUL:  state_nxt = ST_WR;
			ST_WR:   state_nxt = stat.produce ? ST_RD_L : ST_IDLE;
			ST_RD_L: state_nxt = ST_RD_C;
			ST_RD_C: state_nxt = ST_RD_R;
			ST_RD_R: state_nxt = ST_RD_W;
			ST_RD_W: state_nxt = ST_EMIT;
			ST_EMIT: state_nxt = stat.out_free ? ST_IDLE : ST_EMIT;
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		in_ready   = (state_q == ST_IDLE);
		cmd.pixel  = (state_q == ST_IDLE) && in_valid && !in_func && !stat.done;
		cmd.mul    = (state_q == ST_MUL);
		cmd.write  = (state_q == ST_WR);
		cmd.rd_en  = (state_q == ST_RD_L) || (state_q == ST_RD_C) || (state_q == ST_RD_R);
		cmd.shift  = (state_q == ST_RD_C) || (state_q == ST_RD_R) || (state_q == ST_RD_W);
		cmd.emit   = (state_q == ST_EMIT) && stat.out_free;
		unique case (state_q)
			ST_RD_C: cmd.rd_col = COL_CENTRE;
			ST_RD_R: cmd.rd_col = COL_RIGHT;
			default: cmd.rd_col = COL_LEFT;
		endcase
	end

endmodule

FILE: rtl/core/snm_datapath.sv
// Datapath: height conversion, three row stores, 3x3 window, Sobel and output register.
`timescale 1ns / 1ps

module snm_datapath #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  snm_pkg::dp_cmd_t           cmd,
	output snm_pkg::dp_stat_t          stat,
	input  logic [snm_pkg::DIM_W-1:0]  frame_width,
	input  logic [snm_pkg::DIM_W-1:0]  frame_height,
	input  logic [snm_pkg::GAIN_W-1:0] height_gain,
	input  logic [snm_pkg::PIX_W-1:0]  flat_blue,
	input  logic [snm_pkg::PIX_W-1:0]  pix_red,
	input  logic [snm_pkg::PIX_W-1:0]  pix_green,
	input  logic [snm_pkg::PIX_W-1:0]  pix_blue,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [snm_pkg::PIX_W-1:0]  normal_red,
	output logic [snm_pkg::PIX_W-1:0]  normal_green,
	output logic [snm_pkg::PIX_W-1:0]  normal_blue,
	output logic                       end_of_frame
);
	import snm_pkg::*;

	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int WW   = $clog2(MAX_WIDTH + 1);
	localparam int RW   = $clog2(MAX_HEIGHT);
	localparam int HW   = $clog2(MAX_HEIGHT + 1);
	localparam int WCMP = (WW > DIM_W) ? WW : DIM_W;
	localparam int HCMP = (HW > DIM_W) ? HW : DIM_W;

	typedef struct packed {
		logic [PIX_W-1:0] t;
		logic [PIX_W-1:0] m;
		logic [PIX_W-1:0] b;
	} win_col_t;

	// Frame size, latched at the first pixel of a frame
	logic [WW-1:0] cur_w_q;
	logic [HW-1:0] cur_h_q;
	logic [WW-1:0] w_clamped;
	logic [HW-1:0] h_clamped;

	// Input and output position
	logic [CW-1:0] in_col_q;
	logic [RW-1:0] in_row_q;
	logic [1:0]    in_row3_q;
	logic          done_q;
	logic [CW-1:0] ox_q;
	logic [RW-1:0] oy_q;
	logic [1:0]    orow3_q;

	// Height path
	logic [LUMA_W-1:0] luma_q;
	logic [PROD_W-1:0] prod;
	logic [PIX_W-1:0]  height_q;

	// Row stores and window
	logic [PIX_W-1:0] row_mem [3][MAX_WIDTH];
	logic [PIX_W-1:0] rd_data_q [3];
	logic [CW-1:0]    rd_addr;
	logic [1:0]       sel_t;
	logic [1:0]       sel_m;
	logic [1:0]       sel_b;
	win_col_t         win_l_q;
	win_col_t         win_c_q;
	win_col_t         win_r_q;

	// Control helpers
	logic in_col_last;
	logic in_row_last;
	logic out_col_last;
	logic out_row_last;
	logic out_last;

	// Sobel
	logic [9:0]              gx_pos;
	logic [9:0]              gx_neg;
	logic [9:0]              gy_pos;
	logic [9:0]              gy_neg;
	logic signed [GRAD_W-1:0] gx;
	logic signed [GRAD_W-1:0] gy;

	logic out_valid_q;

	// Frame size clamp: zero acts as one, oversize acts as the maximum
	always_comb begin
		if (frame_width == '0)
			w_clamped = WW'(1);
		else if (WCMP'(frame_width) > WCMP'(MAX_WIDTH))
			w_clamped = WW'(MAX_WIDTH);
		else
			w_clamped = WW'(frame_width);
		if (frame_height == '0)
			h_clamped = HW'(1);
		else if (HCMP'(frame_height) > HCMP'(MAX_HEIGHT))
			h_clamped = HW'(MAX_HEIGHT);
		else
			h_clamped = HW'(frame_height);
	end

	assign in_col_last  = (WW'(in_col_q) + WW'(1)) >= cur_w_q;
	assign in_row_last  = (HW'(in_row_q) + HW'(1)) >= cur_h_q;
	assign out_col_last = (WW'(ox_q) + WW'(1)) >= cur_w_q;
	assign out_row_last = (HW'(oy_q) + HW'(1)) >= cur_h_q;
	assign out_last     = out_col_last && out_row_last;

	// Luma at accept, gain multiply in the next step
	assign prod = PROD_W'(luma_q) * PROD_W'(height_gain);

	always_ff @(posedge clk) begin
		if (cmd.pixel)
			luma_q <= LUMA_W'(pix_red) * LUMA_WR + LUMA_W'(pix_green) * LUMA_WG
				+ LUMA_W'(pix_blue) * LUMA_WB;
		if (cmd.mul)
			height_q <= (prod[PROD_W-1:LUMA_W] > (PROD_W-LUMA_W)'(255))
				? '1 : prod[LUMA_W +: PIX_W];
	end

	// Position counters and frame size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_w_q   <= WW'(MAX_WIDTH);
			cur_h_q   <= HW'(MAX_HEIGHT);
			in_col_q  <= '0;
			in_row_q  <= '0;
			in_row3_q <= '0;
			done_q    <= 1'b0;
			ox_q      <= '0;
			oy_q      <= '0;
			orow3_q   <= '0;
		end else begin
			if (cmd.pixel && in_col_q == '0 && in_row_q == '0) begin
				cur_w_q <= w_clamped;
				cur_h_q <= h_clamped;
			end
			if (cmd.write) begin
				if (in_col_last) begin
					in_col_q <= '0;
					if (in_row_last) begin
						done_q <= 1'b1;
					end else begin
						in_row_q  <= in_row_q + RW'(1);
						in_row3_q <= row3_inc(in_row3_q);
					end
				end else begin
					in_col_q <= in_col_q + CW'(1);
				end
			end
			if (cmd.emit) begin
				if (out_last) begin
					// frame complete: everything back to the start
					in_col_q  <= '0;
					in_row_q  <= '0;
					in_row3_q <= '0;
					done_q    <= 1'b0;
					ox_q      <= '0;
					oy_q      <= '0;
					orow3_q   <= '0;
				end else if (out_col_last) begin
					ox_q    <= '0;
					oy_q    <= oy_q + RW'(1);
					orow3_q <= row3_inc(orow3_q);
				end else begin
					ox_q <= ox_q + CW'(1);
				end
			end
		end
	end

	// Window column address with edge replication
	always_comb begin
		unique case (cmd.rd_col)
			COL_LEFT:   rd_addr = (ox_q == '0) ? '0 : ox_q - CW'(1);
			COL_CENTRE: rd_addr = ox_q;
			COL_RIGHT:  rd_addr = out_col_last ? CW'(cur_w_q - WW'(1)) : ox_q + CW'(1);
			default:    rd_addr = ox_q;
		endcase
	end

	// Row slots for top, middle and bottom, replicated at the frame edges
	assign sel_m = orow3_q;
	assign sel_t = (oy_q == '0) ? orow3_q : row3_dec(orow3_q);
	assign sel_b = out_row_last ? orow3_q : row3_inc(orow3_q);

	// Row stores: one write and one registered read per store
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			if (cmd.write && in_row3_q == 2'(k))
				row_mem[k][in_col_q] <= height_q;
			if (cmd.rd_en)
				rd_data_q[k] <= row_mem[k][rd_addr];
		end
	end

	// Window shift: left <- centre <- right <- fresh column
	always_ff @(posedge clk) begin
		if (cmd.shift) begin
			win_l_q <= win_c_q;
			win_c_q <= win_r_q;
			win_r_q <= '{t: rd_data_q[sel_t], m: rd_data_q[sel_m], b: rd_data_q[sel_b]};
		end
	end

	// Sobel gradients
	always_comb begin
		gx_pos = 10'(win_r_q.t) + {1'b0, win_r_q.m, 1'b0} + 10'(win_r_q.b);
		gx_neg = 10'(win_l_q.t) + {1'b0, win_l_q.m, 1'b0} + 10'(win_l_q.b);
		gy_pos = 10'(win_l_q.b) + {1'b0, win_c_q.b, 1'b0} + 10'(win_r_q.b);
		gy_neg = 10'(win_l_q.t) + {1'b0, win_c_q.t, 1'b0} + 10'(win_r_q.t);
		gx     = $signed(GRAD_W'(gx_pos)) - $signed(GRAD_W'(gx_neg));
		gy     = $signed(GRAD_W'(gy_pos)) - $signed(GRAD_W'(gy_neg));
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			normal_red   <= encode_grad(gx);
			normal_green <= encode_grad(gy);
			normal_blue  <= flat_blue;
			end_of_frame <= out_last;
		end
	end

	assign out_valid = out_valid_q;

	// Status: a result is due once the pixel just stored lies past one row and one pixel
	assign stat.done     = done_q;
	assign stat.produce  = (in_row_q >= RW'(2)) || (in_row_q == RW'(1) && in_col_q != '0);
	assign stat.out_free = !out_valid_q || out_ready;

endmodule

FILE: rtl/core/sobel_normal_map_generator_unit.sv
// Sobel normal-map generator: top level with configuration registers.
//
// Source channel src carries RGB pixels in raster order (func = 0) or drain
// ticks (func = 1); each is one beat. Result channel dst carries one normal
// pixel per beat: red and green hold the encoded Sobel gradients, blue the
// flat_blue register, end_of_frame marks the last pixel of the frame.
// Configuration is a plain write port: cfg_index selects the register.
// Output n leaves on the beat that brings pixel n + width + 1; after the
// last source pixel, each further beat flushes one pending output.
// A pixel beat passes the luma, gain-multiply and store-write steps; one
// with a result adds the window fetch and the emit step, and a flushed
// result takes fetch and emit alone. The fetch is sequential: each row
// store has one read port, so the three window columns are read in turn.
// Reset clears all counters and loads the register defaults; the row stores
// are left uninitialised and need no clearing pass.
// A stalled receiver holds the result in the output register; the next beat
// is still accepted, and the block waits at its emit step if it has a
// further result before the held one is taken.
`timescale 1ns / 1ps

module sobel_normal_map_generator_unit #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	snm_pix_if.sink                        src,
	snm_nrm_if.source                      dst,
	input  logic                           cfg_wen,
	input  snm_pkg::reg_idx_t              cfg_index,
	input  logic [snm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import snm_pkg::*;

	logic [DIM_W-1:0]  frame_width_q;
	logic [DIM_W-1:0]  frame_height_q;
	logic [GAIN_W-1:0] height_gain_q;
	logic [PIX_W-1:0]  flat_blue_q;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
			height_gain_q  <= HEIGHT_GAIN_RST;
			flat_blue_q    <= FLAT_BLUE_RST;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_wdata[DIM_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_wdata[DIM_W-1:0];
				REG_HEIGHT_GAIN:  height_gain_q  <= cfg_wdata[GAIN_W-1:0];
				REG_FLAT_BLUE:    flat_blue_q    <= cfg_wdata[PIX_W-1:0];
				default: ;
			endcase
		end
	end

	// Controller
	snm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (src.valid),
		.in_func  (src.func),
		.in_ready (src.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Datapath
	snm_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.frame_width  (frame_width_q),
		.frame_height (frame_height_q),
		.height_gain  (height_gain_q),
		.flat_blue    (flat_blue_q),
		.pix_red      (src.pix_red),
		.pix_green    (src.pix_green),
		.pix_blue     (src.pix_blue),
		.out_valid    (dst.valid),
		.out_ready    (dst.ready),
		.normal_red   (dst.normal_red),
		.normal_green (dst.normal_green),
		.normal_blue  (dst.normal_blue),
		.end_of_frame (dst.end_of_frame)
	);

endmodule

FILE: rtl/core/snm_checker.sv
// Port-level checker for the Sobel normal-map generator and its bind.
`timescale 1ns / 1ps

module snm_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      src_valid,
	input logic                      src_ready,
	input logic                      src_func,
	input logic                      dst_valid,
	input logic                      dst_ready,
	input logic [snm_pkg::PIX_W-1:0] dst_red,
	input logic [snm_pkg::PIX_W-1:0] dst_green,
	input logic [snm_pkg::PIX_W-1:0] dst_blue,
	input logic                      dst_eof
);

	// A waiting result beat stays offered
	a_dst_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && !dst_ready |=> dst_valid)
		else $error("result beat withdrawn before it was taken");

	// A waiting result beat keeps its payload
	a_dst_stable: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && !dst_ready |=> $stable({dst_red, dst_green, dst_blue, dst_eof}))
		else $error("result payload changed while stalled");

	// A pixel beat holds the source off through the multiply and write steps
	a_pixel_busy: assert property (@(posedge clk) disable iff (!arst_n)
		src_valid && src_ready && !src_func |=> !src_ready ##1 !src_ready)
		else $error("source accepted again too soon after a pixel beat");

	// A fresh result only comes out of the emit step, where the source is held off
	a_result_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(dst_valid) |-> $past(!src_ready))
		else $error("result appeared without a preceding emit step");

endmodule

bind sobel_normal_map_generator_unit snm_checker u_snm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.src_valid (src.valid),
	.src_ready (src.ready),
	.src_func  (src.func),
	.dst_valid (dst.valid),
	.dst_ready (dst.ready),
	.dst_red   (dst.normal_red),
	.dst_green (dst.normal_green),
	.dst_blue  (dst.normal_blue),
	.dst_eof   (dst.end_of_frame)
);
